// File: rtl/dmc_pkg.sv
package dmc_pkg;

	// Fixed field widths of the request and result ports.
	localparam int ADDR_W      = 10;
	localparam int DATA_W      = 32;
	localparam int LINE_OUT_W  = 6;
	localparam int WORD_W      = 4;
	localparam int TAG_W       = ADDR_W;

	// Geometry limits independent of the memory sizes.
	localparam int CACHE_LOG2_MAX = 10;
	localparam int BLOCK_LOG2_MAX = 4;
	localparam int BCNT_W         = BLOCK_LOG2_MAX + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;
	localparam logic [3:0] CACHE_LOG2_RST = 4'd6;
	localparam logic [2:0] BLOCK_LOG2_RST = 3'd2;

	// Default sizes.
	localparam int MEM_WORDS_DEF       = 1024;
	localparam int MAX_LINES_DEF       = 64;
	localparam int MAX_BLOCK_WORDS_DEF = 16;

endpackage

// File: rtl/dmc_ram.sv
module dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/direct_mapped_write_through_cache.sv
// Direct-mapped, write-through, write-allocate cache with its main memory built in.
// A request is taken when start is high and busy is low; its result appears on the
// result ports for exactly one cycle, marked by done, and cannot be held off. A hit
// passes through accept, address decode, tag/data RAM read and tag compare. A miss
// adds a line fill, one main-memory word per cycle through the single fill read
// port. A new request may be accepted in the cycle done is high. After reset the
// main memory is loaded with its initial contents by a sweep over all MEM_WORDS
// words, one word per cycle, during which busy stays high; configuration writes
// are taken at any time. Any configuration write to a defined register
// invalidates the whole cache.
module direct_mapped_write_through_cache #(
	parameter int MEM_WORDS       = dmc_pkg::MEM_WORDS_DEF,
	parameter int MAX_LINES       = dmc_pkg::MAX_LINES_DEF,
	parameter int MAX_BLOCK_WORDS = dmc_pkg::MAX_BLOCK_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic        [dmc_pkg::ADDR_W-1:0]   address,
	input  logic signed [dmc_pkg::DATA_W-1:0]   write_data,
	output logic                                done,
	output logic signed [dmc_pkg::DATA_W-1:0]   data,
	output logic                                hit,
	output logic        [dmc_pkg::LINE_OUT_W-1:0] line,
	output logic        [dmc_pkg::WORD_W-1:0]   word,
	output logic        [dmc_pkg::TAG_W-1:0]    tag,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [dmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dmc_pkg::*;

	localparam int MAW       = $clog2(MEM_WORDS);
	localparam int LW        = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int DDEPTH    = MAX_LINES * MAX_BLOCK_WORDS;
	localparam int DAW       = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
	localparam int MEM_LOG   = $clog2(MEM_WORDS + 1) - 1;
	localparam int LINE_LOG  = $clog2(MAX_LINES + 1) - 1;
	localparam int BLK_LOG   = $clog2(MAX_BLOCK_WORDS + 1) - 1;
	localparam int C_CAP     = (MEM_LOG < CACHE_LOG2_MAX) ? MEM_LOG : CACHE_LOG2_MAX;
	localparam int B_CAP     = (BLK_LOG < BLOCK_LOG2_MAX) ? BLK_LOG : BLOCK_LOG2_MAX;
	localparam int ADDR_SPAN = 1 << ADDR_W;
	localparam int MOD_STEPS = $clog2((ADDR_SPAN + MEM_WORDS - 1) / MEM_WORDS);
	localparam int SUMW      = (MAW + 1 > ADDR_W + 1) ? MAW + 1 : ADDR_W + 1;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_TAG  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_FILL = 3'd5;

	// Reduce an address modulo the memory size by conditional subtraction of
	// shifted copies of the size, most significant first.
	function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] a);
		logic [ADDR_W:0] v;
		v = {1'b0, a};
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (v >= (ADDR_W + 1)'(MEM_WORDS << k)) begin
				v = v - (ADDR_W + 1)'(MEM_WORDS << k);
			end
		end
		return ADDR_W'(v);
	endfunction

	logic [2:0]            state_q;
	logic [MAW-1:0]        init_cnt_q;
	logic [BCNT_W-1:0]     fill_rd_q;
	logic                  fill_wr_vld_q;
	logic [WORD_W-1:0]     fill_wr_off_q;
	logic                  done_q;
	logic [3:0]            cache_log2_q;
	logic [2:0]            block_log2_q;
	logic [MAX_LINES-1:0]  valid_q;

	logic                  wr_q;
	logic [ADDR_W-1:0]     addr_raw_q;
	logic [DATA_W-1:0]     wdata_q;
	logic [3:0]            cw_q;
	logic [2:0]            bw_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [ADDR_W-1:0]     base_q;
	logic [LW-1:0]         ln_q;
	logic [WORD_W-1:0]     wd_q;
	logic [TAG_W-1:0]      tg_q;
	logic [DAW-1:0]        lbase_q;
	logic [DATA_W-1:0]     data_q;
	logic                  hit_q;

	logic [4:0]            c1, b1, b2, c2;
	logic [3:0]            geo_cw;
	logic [2:0]            geo_bw;
	logic [ADDR_W-1:0]     addr_w, addr_m;
	logic [LW-1:0]         ln_n;
	logic [WORD_W-1:0]     wd_n;
	logic [TAG_W-1:0]      tg_n;
	logic [DAW-1:0]        lbase_n;
	logic [BCNT_W-1:0]     bsize;
	logic [SUMW-1:0]       fsum;
	logic                  hit_now;
	logic                  cfg_wr;
	logic                  fill_last;

	logic                  mem_we;
	logic [MAW-1:0]        mem_waddr, mem_raddr;
	logic [DATA_W-1:0]     mem_wdata, mem_rdata;
	logic                  dat_we;
	logic [DAW-1:0]        dat_waddr, dat_raddr;
	logic [DATA_W-1:0]     dat_wdata, dat_rdata;
	logic                  tag_we;
	logic [TAG_W-1:0]      tag_rdata;

	// Effective geometry from the configuration registers.
	always_comb begin
		c1 = ({1'b0, cache_log2_q} > 5'(C_CAP)) ? 5'(C_CAP) : {1'b0, cache_log2_q};
		b1 = ({2'b0, block_log2_q} > 5'(B_CAP)) ? 5'(B_CAP) : {2'b0, block_log2_q};
		b2 = (b1 > c1) ? c1 : b1;
		c2 = (c1 > b2 + 5'(LINE_LOG)) ? b2 + 5'(LINE_LOG) : c1;
		geo_cw = 4'(c2);
		geo_bw = 3'(b2);
	end

	// Address decode for the captured request.
	always_comb begin
		addr_w  = wrap_addr(addr_raw_q);
		addr_m  = addr_w & ~({ADDR_W{1'b1}} << cw_q);
		ln_n    = LW'(addr_m >> bw_q);
		wd_n    = WORD_W'(addr_w & ~({ADDR_W{1'b1}} << bw_q));
		tg_n    = TAG_W'(addr_w >> cw_q);
		lbase_n = DAW'(ln_n * MAX_BLOCK_WORDS);
	end

	assign bsize     = BCNT_W'(1) << bw_q;
	assign hit_now   = valid_q[ln_q] && (tag_rdata == tg_q);
	assign fill_last = fill_wr_vld_q && (BCNT_W'(fill_wr_off_q) == bsize - BCNT_W'(1));
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready
		&& ((cfg_index == CFG_CACHE_LOG2) || (cfg_index == CFG_BLOCK_LOG2));

	// Fill read address wraps around the end of main memory.
	always_comb begin
		fsum = SUMW'(base_q) + SUMW'(fill_rd_q);
		if (fsum >= SUMW'(MEM_WORDS)) begin
			fsum = fsum - SUMW'(MEM_WORDS);
		end
		mem_raddr = MAW'(fsum);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = MAW'(addr_q);
		mem_wdata = wdata_q;
		if (state_q == S_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = init_cnt_q;
			mem_wdata = DATA_W'(MEM_WORDS) - DATA_W'(init_cnt_q);
		end else if (state_q == S_CHK && wr_q) begin
			mem_we = 1'b1;
		end
	end

	assign dat_raddr = lbase_q + DAW'(wd_q);

	always_comb begin
		dat_we    = 1'b0;
		dat_waddr = dat_raddr;
		dat_wdata = wdata_q;
		if (state_q == S_CHK && wr_q && hit_now) begin
			dat_we = 1'b1;
		end else if (state_q == S_FILL && fill_wr_vld_q) begin
			dat_we    = 1'b1;
			dat_waddr = lbase_q + DAW'(fill_wr_off_q);
			dat_wdata = mem_rdata;
		end
	end

	assign tag_we = (state_q == S_CHK) && !hit_now;

	dmc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dmc_ram #(.WIDTH(DATA_W), .DEPTH(DDEPTH)) u_data (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wdata),
		.raddr (dat_raddr),
		.rdata (dat_rdata)
	);

	dmc_ram #(.WIDTH(TAG_W), .DEPTH(MAX_LINES)) u_tag (
		.clk   (clk),
		.we    (tag_we),
		.waddr (ln_q),
		.wdata (tg_q),
		.raddr (ln_q),
		.rdata (tag_rdata)
	);

	// Configuration registers and line valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_log2_q <= CACHE_LOG2_RST;
			block_log2_q <= BLOCK_LOG2_RST;
			valid_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CACHE_LOG2: cache_log2_q <= cfg_data;
					CFG_BLOCK_LOG2: block_log2_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cfg_wr) begin
				valid_q <= '0;
			end else if (state_q == S_CHK && !hit_now) begin
				valid_q[ln_q] <= 1'b1;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			init_cnt_q    <= '0;
			fill_rd_q     <= '0;
			fill_wr_vld_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + MAW'(1);
					if (init_cnt_q == MAW'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= S_TAG;
				S_TAG:  state_q <= S_CHK;
				S_CHK: begin
					fill_rd_q     <= '0;
					fill_wr_vld_q <= 1'b0;
					if (hit_now) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					// Reads run ahead of the line writes; each write takes the registered read offset.
					if (fill_rd_q < bsize) begin
						fill_rd_q <= fill_rd_q + BCNT_W'(1);
					end
					fill_wr_vld_q <= (fill_rd_q < bsize);
					if (fill_last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			wr_q       <= req_type;
			addr_raw_q <= address;
			wdata_q    <= write_data;
			cw_q       <= geo_cw;
			bw_q       <= geo_bw;
		end
		if (state_q == S_ADDR) begin
			addr_q  <= addr_w;
			base_q  <= addr_w - ADDR_W'(wd_n);
			ln_q    <= ln_n;
			wd_q    <= wd_n;
			tg_q    <= tg_n;
			lbase_q <= lbase_n;
		end
		if (state_q == S_CHK) begin
			hit_q  <= hit_now;
			data_q <= wr_q ? wdata_q : dat_rdata;
		end
		fill_wr_off_q <= WORD_W'(fill_rd_q);
		if (state_q == S_FILL && fill_wr_vld_q && fill_wr_off_q == wd_q) begin
			data_q <= mem_rdata;
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign data  = data_q;
	assign hit   = hit_q;
	assign line  = LINE_OUT_W'(ln_q);
	assign word  = wd_q;
	assign tag   = tg_q;

endmodule

// File: rtl/dmc_checker.sv
module dmc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted request always raises busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// A result appears only as the block returns to idle after working.
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a transaction");

	// The result strobe is never held: done always falls after it rises.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

bind direct_mapped_write_through_cache dmc_checker u_dmc_checker (.*);

// File: verif/direct_mapped_write_through_cache_checker.sv
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic                                  req_type,
	input  logic        [dmc_pkg::ADDR_W-1:0]     address,
	input  logic signed [dmc_pkg::DATA_W-1:0]     write_data,
	input  logic                                  done,
	input  logic signed [dmc_pkg::DATA_W-1:0]     data,
	input  logic                                  hit,
	input  logic        [dmc_pkg::LINE_OUT_W-1:0] line,
	input  logic        [dmc_pkg::WORD_W-1:0]     word,
	input  logic        [dmc_pkg::TAG_W-1:0]      tag,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic        [dmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [dmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                    mismatches,
	output int                                    pending
);
	import dmc_pkg::*;

	localparam int LINES_LOG2 = $clog2(MAX_LINES_DEF);

	typedef struct packed {
		logic [ADDR_W-1:0]     address;
		logic [DATA_W-1:0]     data;
		logic                  hit;
		logic [LINE_OUT_W-1:0] line;
		logic [WORD_W-1:0]     word;
		logic [TAG_W-1:0]      tag;
	} access_result_t;

	logic [3:0]        cache_log2;
	logic [2:0]        block_log2;
	logic [DATA_W-1:0] mem_words [MEM_WORDS_DEF];
	logic [DATA_W-1:0] cached_words [MAX_LINES_DEF*MAX_BLOCK_WORDS_DEF];
	logic [ADDR_W-1:0] line_tags [MAX_LINES_DEF];
	logic              line_valids [MAX_LINES_DEF];
	access_result_t    awaited_results [$];

	task automatic report(input string what);
		$display("%0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic invalidate_all();
		foreach (line_valids[i])
			line_valids[i] = 1'b0;
	endtask

	// Applies the saturation rules to the programmed sizes; the cache never has more
	// lines than MAX_LINES, so an oversized cache shrinks to fit the block size.
	function automatic void effective_geometry(output int cw, output int bw);
		int c;
		int b;
		c = cache_log2;
		b = block_log2;
		if (c > CACHE_LOG2_MAX)
			c = CACHE_LOG2_MAX;
		if (b > BLOCK_LOG2_MAX)
			b = BLOCK_LOG2_MAX;
		if (b > c)
			b = c;
		while (c - b > LINES_LOG2)
			c--;
		cw = c;
		bw = b;
	endfunction

	function automatic access_result_t predict_access(input logic is_write,
			input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] value);
		access_result_t r;
		int cw;
		int bw;
		int ln;
		int wd;
		int tg;
		int base;
		effective_geometry(cw, bw);
		ln = (a & ((1 << cw) - 1)) >> bw;
		wd = a & ((1 << bw) - 1);
		tg = a >> cw;
		base = a - wd;
		r.address = a;
		r.hit = line_valids[ln] && line_tags[ln] == ADDR_W'(tg);
		r.line = LINE_OUT_W'(ln);
		r.word = WORD_W'(wd);
		r.tag = TAG_W'(tg);
		// Write-through: main memory is updated first, so a write-allocate fill
		// already carries the new value.
		if (is_write)
			mem_words[a] = value;
		if (is_write && r.hit) begin
			cached_words[ln*MAX_BLOCK_WORDS_DEF + wd] = value;
		end else if (!r.hit) begin
			for (int i = 0; i < (1 << bw); i++)
				cached_words[ln*MAX_BLOCK_WORDS_DEF + i] = mem_words[(base + i) % MEM_WORDS_DEF];
			line_tags[ln] = ADDR_W'(tg);
			line_valids[ln] = 1'b1;
		end
		r.data = is_write ? value : cached_words[ln*MAX_BLOCK_WORDS_DEF + wd];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		access_result_t exp_r;
		if (!arst_n) begin
			cache_log2 = CACHE_LOG2_RST;
			block_log2 = BLOCK_LOG2_RST;
			foreach (mem_words[i])
				mem_words[i] = MEM_WORDS_DEF - i;
			foreach (cached_words[i])
				cached_words[i] = '0;
			foreach (line_tags[i])
				line_tags[i] = '0;
			invalidate_all();
			awaited_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// Retire first: a new request may be taken in the cycle a result leaves.
			if (done) begin
				if (awaited_results.size() == 0) begin
					report($sformatf("result with no request outstanding (data %0d)", data));
				end else begin
					exp_r = awaited_results.pop_front();
					if (data !== exp_r.data)
						report($sformatf("address %0d: data %0d, expected %0d",
							exp_r.address, data, $signed(exp_r.data)));
					if (hit !== exp_r.hit)
						report($sformatf("address %0d: hit %b, expected %b",
							exp_r.address, hit, exp_r.hit));
					if (line !== exp_r.line)
						report($sformatf("address %0d: line %0d, expected %0d",
							exp_r.address, line, exp_r.line));
					if (word !== exp_r.word)
						report($sformatf("address %0d: word %0d, expected %0d",
							exp_r.address, word, exp_r.word));
					if (tag !== exp_r.tag)
						report($sformatf("address %0d: tag %0d, expected %0d",
							exp_r.address, tag, exp_r.tag));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CACHE_LOG2: begin
						cache_log2 = cfg_data;
						invalidate_all();
					end
					CFG_BLOCK_LOG2: begin
						block_log2 = cfg_data[2:0];
						invalidate_all();
					end
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_results.push_back(predict_access(req_type, address, write_data));
			pending <= awaited_results.size();
		end
	end

endmodule

// File: verif/direct_mapped_write_through_cache_tb.sv
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_tb;
	import dmc_pkg::*;

	localparam int ITEM_TARGET = 1150;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic REQ_READ = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         req_type;
	logic        [ADDR_W-1:0]     address;
	logic signed [DATA_W-1:0]     write_data;
	logic                         done;
	logic signed [DATA_W-1:0]     data;
	logic                         hit;
	logic        [LINE_OUT_W-1:0] line;
	logic        [WORD_W-1:0]     word;
	logic        [TAG_W-1:0]      tag;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic        [CFG_IDX_W-1:0]  cfg_index;
	logic        [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int pending;
	int items_sent;
	int idle_cycles;
	logic [ADDR_W-1:0] hot_addrs [8];

	direct_mapped_write_through_cache dut (.*);

	direct_mapped_write_through_cache_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Ends the run if no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic rt, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] value);
		start <= 1'b1;
		req_type <= rt;
		address <= a;
		write_data <= value;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_geometry(input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] b);
		drain();
		write_reg(CFG_CACHE_LOG2, c);
		write_reg(CFG_BLOCK_LOG2, b);
		cfg_valid <= 1'b0;
	endtask

	// Addresses mostly cluster around a small hot set, so lines get reused and
	// evicted by conflicting tags; the rest are spread over the whole memory.
	task automatic random_request();
		int sel;
		int idx;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] value;
		sel = $urandom_range(0, 99);
		idx = $urandom_range(0, 7);
		if (sel < 45) begin
			a = hot_addrs[idx] ^ ADDR_W'($urandom_range(0, 15));
		end else if (sel < 75) begin
			a = hot_addrs[idx] ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
		end else begin
			a = ADDR_W'($urandom);
			hot_addrs[idx] = a;
		end
		case ($urandom_range(0, 19))
			0: value = '0;
			1: value = '1;
			2: value = 32'h8000_0000;
			3: value = 32'h7FFF_FFFF;
			default: value = $urandom;
		endcase
		send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, a, value);
	endtask

	task automatic run_random(input int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				random_request();
				left--;
				burst--;
			end
			case ($urandom_range(0, 11))
				0, 1, 2: ;
				11: drain();
				default: begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_READ;
		address = '0;
		write_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CACHE_LOG2;
		cfg_data = '0;
		items_sent = 0;
		foreach (hot_addrs[i])
			hot_addrs[i] = ADDR_W'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Default geometry: 64 words, blocks of 4, so 16 lines.
		set_geometry(4'd6, 4'd2);
		send_request(REQ_READ, 10'd0, '0);
		send_request(REQ_READ, 10'd3, '1);
		send_request(REQ_WRITE, 10'd1, 32'h7FFF_FFFF);
		send_request(REQ_READ, 10'd1, '0);
		send_request(REQ_READ, 10'd64, '0);
		send_request(REQ_READ, 10'd1, '0);
		send_request(REQ_WRITE, 10'd1023, 32'h8000_0000);
		send_request(REQ_READ, 10'd1023, '0);
		send_request(REQ_READ, 10'd1020, '0);
		send_request(REQ_WRITE, 10'd1020, '1);
		send_request(REQ_WRITE, 10'd512, '0);
		send_request(REQ_READ, 10'd513, '0);
		send_request(REQ_READ, 10'd1022, '0);
		// A write to an unmapped register index must leave the cache contents valid.
		drain();
		write_reg(CFG_UNMAPPED, 4'hF);
		cfg_valid <= 1'b0;
		send_request(REQ_READ, 10'd1023, '0);
		send_request(REQ_WRITE, 10'd0, 32'h5555_5555);
		send_request(REQ_READ, 10'd2, '0);
		send_request(REQ_READ, 10'd512, '0);

		// Extremes of both registers, including saturating and oversized settings.
		set_geometry(4'd0, 4'd0);
		run_random(50);
		set_geometry(4'd15, 4'd7);
		run_random(50);
		set_geometry(4'd10, 4'd0);
		run_random(50);
		set_geometry(4'd1, 4'd4);
		run_random(50);
		set_geometry(4'd4, 4'd15);
		run_random(50);
		set_geometry(4'd3, 4'd3);
		run_random(50);
		set_geometry(4'd8, 4'd1);
		run_random(50);
		set_geometry(4'd6, 4'd2);
		run_random(50);

		while (items_sent < ITEM_TARGET) begin
			set_geometry(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
			run_random($urandom_range(30, 120));
		end

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
